// File: hw/rtl/scfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared constants, types and the CRC byte step for the sync/CRC frame
// receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int FRAME_BYTES   = 31;
    localparam int FEATURE_COUNT = 10;

    localparam int ADDR_W     = $clog2(FRAME_BYTES);
    localparam int CNT_W      = $clog2(FRAME_BYTES + 1);
    localparam int FCNT_W     = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int FIDX_W     = 4;
    localparam int CFG_IDX_W  = 2;

    // frame layout
    localparam int CRC_LEN    = FRAME_BYTES - 2;
    localparam int STATUS_POS = FRAME_BYTES - 3;
    localparam int CRC_POS    = FRAME_BYTES - 2;
    localparam int FEAT_BASE  = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [7:0] VERSION_RST     = 8'h01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_EXP_VERSION = 2'd2
    } cfg_idx_t;

    // what the datapath does with read data coming back from the buffer
    typedef enum logic [1:0] {
        SW_NONE,
        SW_CRC,
        SW_SCAN,
        SW_COPY
    } sweep_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRC,
        ST_CRC_DRAIN,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_SCAN_END,
        ST_COPY,
        ST_COPY_DRAIN,
        ST_FEAT_LO,
        ST_FEAT_HI,
        ST_FEAT_OUT
    } state_t;

    typedef struct packed {
        logic   take_byte;
        logic   crc_init;
        logic   scan_init;
        logic   copy_init;
        logic   rd_issue;
        sweep_t sweep;
        logic   set_count;
        logic   clr_count;
        logic   feat_init;
        logic   feat_rd_lo;
        logic   feat_rd_hi;
        logic   feat_cap_lo;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic last_byte;
        logic rd_last;
        logic frame_good;
        logic found;
        logic feat_last;
        logic out_busy;
    } stat_t;

    // CRC16-CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/scfr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_ctrl
// Frame controller: byte collection, CRC sweep, resync scan and copy,
// feature emission.
// ----------------------------------------------------------------------------
module scfr_ctrl
    import scfr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.last_byte) state_next = ST_CRC;
            end
            ST_CRC: begin
                if (stat.rd_last) state_next = ST_CRC_DRAIN;
            end
            ST_CRC_DRAIN: state_next = ST_DECIDE;
            ST_DECIDE: begin
                state_next = stat.frame_good ? ST_FEAT_LO : ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.rd_last) state_next = ST_SCAN_DRAIN;
            end
            ST_SCAN_DRAIN: state_next = ST_SCAN_END;
            ST_SCAN_END: begin
                state_next = stat.found ? ST_COPY : ST_IDLE;
            end
            ST_COPY: begin
                if (stat.rd_last) state_next = ST_COPY_DRAIN;
            end
            ST_COPY_DRAIN: state_next = ST_IDLE;
            ST_FEAT_LO: state_next = ST_FEAT_HI;
            ST_FEAT_HI: state_next = ST_FEAT_OUT;
            ST_FEAT_OUT: begin
                if (!stat.out_busy) begin
                    state_next = stat.feat_last ? ST_IDLE : ST_FEAT_LO;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.take_byte = s_valid;
                cmd.crc_init  = s_valid && stat.last_byte;
            end
            ST_CRC: begin
                cmd.rd_issue = 1'b1;
                cmd.sweep    = SW_CRC;
            end
            ST_CRC_DRAIN: cmd.sweep = SW_CRC;
            ST_DECIDE: begin
                cmd.feat_init = stat.frame_good;
                cmd.scan_init = !stat.frame_good;
            end
            ST_SCAN: begin
                cmd.rd_issue = 1'b1;
                cmd.sweep    = SW_SCAN;
            end
            ST_SCAN_DRAIN: cmd.sweep = SW_SCAN;
            ST_SCAN_END: begin
                cmd.copy_init = stat.found;
                cmd.clr_count = !stat.found;
            end
            ST_COPY: begin
                cmd.rd_issue = 1'b1;
                cmd.sweep    = SW_COPY;
            end
            ST_COPY_DRAIN: begin
                cmd.sweep     = SW_COPY;
                cmd.set_count = 1'b1;
            end
            ST_FEAT_LO: cmd.feat_rd_lo = 1'b1;
            ST_FEAT_HI: begin
                cmd.feat_rd_hi  = 1'b1;
                cmd.feat_cap_lo = 1'b1;
            end
            ST_FEAT_OUT: begin
                cmd.out_load  = !stat.out_busy;
                cmd.clr_count = !stat.out_busy && stat.feat_last;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/scfr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_dp
// Datapath: configuration registers, frame buffer memory, byte counter,
// CRC and header capture, resync scan/copy, output register.
// ----------------------------------------------------------------------------
module scfr_dp
    import scfr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cmd_t                   cmd,
    output stat_t                       stat,
    input  wire logic [7:0]             s_rx_byte,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]             cfg_wdata,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_sequence_res,
    output logic [31:0]                 m_tick_ms,
    output logic [7:0]                  m_status_byte,
    output logic [15:0]                 m_crc_value,
    output logic [FIDX_W-1:0]           m_feature_index,
    output logic signed [15:0]          m_feature_value,
    output logic                        m_last_feature
);

    // configuration
    logic [7:0] sync_first_reg, sync_second_reg, version_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            version_reg     <= VERSION_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                CFG_EXP_VERSION: version_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame buffer
    logic [7:0]        frame_mem [FRAME_BYTES];
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) frame_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en) rd_data_reg <= frame_mem[mem_rd_addr];
    end

    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] dly_addr_reg;
    logic              dly_vld_reg;
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] shift_reg;
    logic              found_reg;
    logic              prev_sf_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        hdr_sync0_reg, hdr_sync1_reg, hdr_ver_reg;
    logic [7:0]        seq_reg, status_reg, feat_lo_reg;
    logic [31:0]       tick_reg;
    logic [15:0]       rx_crc_reg;
    logic [FCNT_W-1:0] feat_idx_reg;
    logic [ADDR_W-1:0] feat_addr;

    assign feat_addr = ADDR_W'(FEAT_BASE + 2 * int'(feat_idx_reg));

    // byte intake, copy writes and counter
    always_comb begin
        byte_count_next = byte_count_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = byte_count_reg[ADDR_W-1:0];
        mem_wr_data     = s_rx_byte;
        if (cmd.take_byte) begin
            priority if (byte_count_reg == '0) begin
                if (s_rx_byte == sync_first_reg) begin
                    mem_wr_en       = 1'b1;
                    byte_count_next = CNT_W'(1);
                end
            end else if (byte_count_reg == CNT_W'(1)) begin
                if (s_rx_byte == sync_second_reg) begin
                    mem_wr_en       = 1'b1;
                    byte_count_next = CNT_W'(2);
                end else if (s_rx_byte == sync_first_reg) begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = '0;
                    byte_count_next = CNT_W'(1);
                end else begin
                    byte_count_next = '0;
                end
            end else if (byte_count_reg >= CNT_W'(FRAME_BYTES)) begin
                byte_count_next = '0;
            end else begin
                mem_wr_en       = 1'b1;
                byte_count_next = byte_count_reg + 1'b1;
            end
        end else if (cmd.sweep == SW_COPY && dly_vld_reg) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wr_ptr_reg;
            mem_wr_data = rd_data_reg;
        end
        if (cmd.set_count) byte_count_next = CNT_W'(FRAME_BYTES) - CNT_W'(shift_reg);
        if (cmd.clr_count) byte_count_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            dly_vld_reg    <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            dly_vld_reg    <= cmd.rd_issue;
        end
    end

    always_comb begin
        mem_rd_en   = cmd.rd_issue | cmd.feat_rd_lo | cmd.feat_rd_hi;
        mem_rd_addr = rd_addr_reg;
        if (cmd.feat_rd_lo) mem_rd_addr = feat_addr;
        if (cmd.feat_rd_hi) mem_rd_addr = feat_addr + 1'b1;
    end

    // sweep address, and consumption of the read data in the cycle after its address
    always_ff @(posedge aclk) begin
        dly_addr_reg <= rd_addr_reg;
        if (cmd.crc_init) begin
            rd_addr_reg <= '0;
            crc_reg     <= CRC_INIT;
        end else if (cmd.scan_init) begin
            rd_addr_reg <= ADDR_W'(1);
            found_reg   <= 1'b0;
            prev_sf_reg <= 1'b0;
        end else if (cmd.copy_init) begin
            rd_addr_reg <= shift_reg;
            wr_ptr_reg  <= '0;
        end else if (cmd.rd_issue) begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
        end

        if (dly_vld_reg) begin
            unique case (cmd.sweep)
                SW_CRC: begin
                    if (dly_addr_reg < ADDR_W'(CRC_LEN)) begin
                        crc_reg <= crc16_byte(crc_reg, rd_data_reg);
                    end
                    if (dly_addr_reg == ADDR_W'(0)) hdr_sync0_reg <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(1)) hdr_sync1_reg <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(2)) hdr_ver_reg   <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(3)) seq_reg       <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(4)) tick_reg[7:0]   <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(5)) tick_reg[15:8]  <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(6)) tick_reg[23:16] <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(7)) tick_reg[31:24] <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(STATUS_POS)) status_reg <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(CRC_POS)) rx_crc_reg[7:0] <= rd_data_reg;
                    if (dly_addr_reg == ADDR_W'(CRC_POS + 1)) begin
                        rx_crc_reg[15:8] <= rd_data_reg;
                    end
                end
                SW_SCAN: begin
                    // first sync pair wins; a lone first sync byte at the end is kept
                    if (!found_reg) begin
                        if (prev_sf_reg && rd_data_reg == sync_second_reg) begin
                            found_reg <= 1'b1;
                            shift_reg <= dly_addr_reg - 1'b1;
                        end else if (dly_addr_reg == ADDR_W'(FRAME_BYTES - 1) &&
                                     rd_data_reg == sync_first_reg) begin
                            found_reg <= 1'b1;
                            shift_reg <= dly_addr_reg;
                        end
                    end
                    prev_sf_reg <= (rd_data_reg == sync_first_reg);
                end
                SW_COPY: wr_ptr_reg <= wr_ptr_reg + 1'b1;
                SW_NONE: ;
                default: ;
            endcase
        end

        if (cmd.feat_init) feat_idx_reg <= '0;
        else if (cmd.out_load) feat_idx_reg <= feat_idx_reg + 1'b1;
        if (cmd.feat_cap_lo) feat_lo_reg <= rd_data_reg;
    end

    // output register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_sequence_res  <= seq_reg;
            m_tick_ms       <= tick_reg;
            m_status_byte   <= status_reg;
            m_crc_value     <= rx_crc_reg;
            m_feature_index <= FIDX_W'(feat_idx_reg);
            m_feature_value <= {rd_data_reg, feat_lo_reg};
            m_last_feature  <= (feat_idx_reg == FCNT_W'(FEATURE_COUNT - 1));
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        stat.last_byte  = (byte_count_reg == CNT_W'(FRAME_BYTES - 1));
        stat.rd_last    = (rd_addr_reg == ADDR_W'(FRAME_BYTES - 1));
        stat.frame_good = (hdr_sync0_reg == sync_first_reg) &&
                          (hdr_sync1_reg == sync_second_reg) &&
                          (hdr_ver_reg == version_reg) &&
                          (rx_crc_reg == crc_reg);
        stat.found      = found_reg;
        stat.feat_last  = (feat_idx_reg == FCNT_W'(FEATURE_COUNT - 1));
        stat.out_busy   = m_valid_reg && !m_ready;
    end

endmodule
`default_nettype wire

// File: hw/rtl/sync_crc_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_crc_frame_receiver
// Sync-word framer with CRC16-CCITT-FALSE check; emits one beat per feature
// of each good frame.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_rx_byte
//   m_        out        m_valid / m_ready    header fields, feature index/value
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// While hunting and collecting, a byte is taken every cycle.
// The last byte of a frame starts a pass over the buffer's single read port:
// a CRC and header capture sweep, then per feature beat a low read, a high
// read and an output load (held while m_ready stalls), or on a bad frame a
// resync scan and, on a hit, a tail copy. s_ready is low during that pass.
// Reset is synchronous; the buffer needs no clearing, only the count resets.
// ----------------------------------------------------------------------------
module sync_crc_frame_receiver
    import scfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_rx_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_sequence_res,
    output logic [31:0]               m_tick_ms,
    output logic [7:0]                m_status_byte,
    output logic [15:0]               m_crc_value,
    output logic [FIDX_W-1:0]         m_feature_index,
    output logic signed [15:0]        m_feature_value,
    output logic                      m_last_feature,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    scfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scfr_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_rx_byte       (s_rx_byte),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sequence_res  (m_sequence_res),
        .m_tick_ms       (m_tick_ms),
        .m_status_byte   (m_status_byte),
        .m_crc_value     (m_crc_value),
        .m_feature_index (m_feature_index),
        .m_feature_value (m_feature_value),
        .m_last_feature  (m_last_feature)
    );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/CRC frame receiver. Bytes go in on the
// s_ channel under random gaps. A frame tracker in the bench follows the sync
// hunt, the frame fill, the CRC/version check and the resync scan, and queues
// the feature beats that each good frame should yield. The m_ channel is
// back-pressured at random, and every beat is compared field by field with
// the oldest queued one. Register writes happen only once the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import scfr_pkg::*;

    localparam int          DRAIN_CYCLES   = 150;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          MAX_PRINTS     = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef enum {FILL_RANDOM, FILL_EXTREMES, FILL_ONES, FILL_ZEROS} fill_t;

    typedef struct packed {
        logic [7:0]        seq;
        logic [31:0]       tick;
        logic [7:0]        status;
        logic [15:0]       crc;
        logic [FIDX_W-1:0] idx;
        logic [15:0]       value;
        logic              last;
    } feat_beat_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [7:0]           m_sequence_res;
    logic [31:0]          m_tick_ms;
    logic [7:0]           m_status_byte;
    logic [15:0]          m_crc_value;
    logic [FIDX_W-1:0]    m_feature_index;
    logic signed [15:0]   m_feature_value;
    logic                 m_last_feature;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = 8'h00;

    // bench copy of the block's registers and frame store
    logic [7:0]   cur_sync_first  = SYNC_FIRST_RST;
    logic [7:0]   cur_sync_second = SYNC_SECOND_RST;
    logic [7:0]   cur_version     = VERSION_RST;
    frame_t       rx_hold;
    int unsigned  rx_count = 0;

    feat_beat_t   expected_feats[$];
    int unsigned  bytes_sent     = 0;
    int unsigned  feats_expected = 0;
    int           err_count      = 0;
    int           src_idle_pct   = 38;
    int           snk_idle_pct   = 48;
    int           quiet_cycles   = 0;

    sync_crc_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sequence_res  (m_sequence_res),
        .m_tick_ms       (m_tick_ms),
        .m_status_byte   (m_status_byte),
        .m_crc_value     (m_crc_value),
        .m_feature_index (m_feature_index),
        .m_feature_value (m_feature_value),
        .m_last_feature  (m_last_feature),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // CRC16-CCITT-FALSE over the first len bytes, MSB first
    function automatic logic [15:0] crc16_false_of(input frame_t f, input int len);
        logic [15:0] c;
        int          i;
        int          b;
        c = CRC_INIT;
        for (i = 0; i < len; i++) begin
            c = c ^ {f[i], 8'h00};
            for (b = 0; b < 8; b++) begin
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
        end
        return c;
    endfunction

    // Follows one accepted byte through hunt, fill, check and resync.
    task automatic decode_rx_byte(input logic [7:0] b);
        logic [15:0] rx_crc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        feat_beat_t  beat;
        int          i;
        int          off;
        int          sh;
        bit          found;
        if (rx_count == 0) begin
            if (b == cur_sync_first) begin
                rx_hold[0] = b;
                rx_count   = 1;
            end
        end else if (rx_count == 1) begin
            if (b == cur_sync_second) begin
                rx_hold[1] = b;
                rx_count   = 2;
            end else if (b == cur_sync_first) begin
                rx_hold[0] = b;
                rx_count   = 1;
            end else begin
                rx_count = 0;
            end
        end else if (rx_count >= FRAME_BYTES) begin
            rx_count = 0;
        end else begin
            rx_hold[rx_count] = b;
            rx_count++;
            if (rx_count == FRAME_BYTES) begin
                rx_crc = {rx_hold[CRC_POS + 1], rx_hold[CRC_POS]};
                if (rx_hold[0] == cur_sync_first && rx_hold[1] == cur_sync_second &&
                    rx_hold[2] == cur_version && rx_crc == crc16_false_of(rx_hold, CRC_LEN)) begin
                    for (i = 0; i < FEATURE_COUNT; i++) begin
                        off          = FEAT_BASE + 2 * i;
                        lo           = (off < FRAME_BYTES) ? rx_hold[off] : 8'h00;
                        hi           = (off + 1 < FRAME_BYTES) ? rx_hold[off + 1] : 8'h00;
                        beat.seq     = rx_hold[3];
                        beat.tick    = {rx_hold[7], rx_hold[6], rx_hold[5], rx_hold[4]};
                        beat.status  = rx_hold[STATUS_POS];
                        beat.crc     = rx_crc;
                        beat.idx     = FIDX_W'(i);
                        beat.value   = {hi, lo};
                        beat.last    = (i == FEATURE_COUNT - 1);
                        expected_feats.push_back(beat);
                        feats_expected++;
                    end
                    rx_count = 0;
                end else begin
                    // look for the next sync pair; a first sync byte in the
                    // last slot is kept on its own
                    found = 1'b0;
                    for (sh = 1; sh < FRAME_BYTES && !found; sh++) begin
                        if (rx_hold[sh] == cur_sync_first &&
                            (sh + 1 >= FRAME_BYTES || rx_hold[sh + 1] == cur_sync_second)) begin
                            for (i = 0; i < FRAME_BYTES - sh; i++)
                                rx_hold[i] = rx_hold[i + sh];
                            rx_count = FRAME_BYTES - sh;
                            found    = 1'b1;
                        end
                    end
                    if (!found)
                        rx_count = 0;
                end
            end
        end
    endtask

    function automatic frame_t build_frame(input logic [7:0] ver, input fill_t fill);
        frame_t      f;
        logic [15:0] crc;
        logic [15:0] fv;
        int          i;
        f[0] = cur_sync_first;
        f[1] = cur_sync_second;
        f[2] = ver;
        for (i = 3; i < CRC_POS; i++) begin
            case (fill)
                FILL_ONES:  f[i] = 8'hFF;
                FILL_ZEROS: f[i] = 8'h00;
                default:    f[i] = 8'($urandom);
            endcase
        end
        if (fill == FILL_EXTREMES) begin
            for (i = 0; i < FEATURE_COUNT; i++) begin
                case (i % 4)
                    0:       fv = 16'h8000;
                    1:       fv = 16'h7FFF;
                    2:       fv = 16'hFFFF;
                    default: fv = 16'h0000;
                endcase
                f[FEAT_BASE + 2 * i]     = fv[7:0];
                f[FEAT_BASE + 2 * i + 1] = fv[15:8];
            end
        end
        crc            = crc16_false_of(f, CRC_LEN);
        f[CRC_POS]     = crc[7:0];
        f[CRC_POS + 1] = crc[15:8];
        return f;
    endfunction

    // One beat on s_. Valid is left high so a following beat can go back to back.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        decode_rx_byte(b);
    endtask

    task automatic send_frame(input frame_t f, input int first, input int last);
        for (int i = first; i <= last; i++)
            send_byte(f[i]);
    endtask

    // A bad frame whose tail from position shift is the head of a good one,
    // followed by the rest of that good frame.
    task automatic send_frame_behind_bad(input int shift);
        frame_t good;
        frame_t bad;
        good = build_frame(cur_version, FILL_RANDOM);
        bad  = build_frame(cur_version, FILL_RANDOM);
        for (int i = shift; i < FRAME_BYTES; i++)
            bad[i] = good[i - shift];
        send_frame(bad, 0, FRAME_BYTES - 1);
        send_frame(good, FRAME_BYTES - shift, FRAME_BYTES - 1);
    endtask

    // Feed a byte that is neither sync value until the tracker is back to hunting.
    task automatic flush_to_hunt();
        logic [7:0] filler;
        filler = 8'h00;
        while (filler == cur_sync_first || filler == cur_sync_second)
            filler++;
        while (rx_count != 0)
            send_byte(filler);
    endtask

    // Stop sending, let all queued beats come out, then let a bad-frame pass finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_feats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SYNC_FIRST:  cur_sync_first  = v;
            CFG_SYNC_SECOND: cur_sync_second = v;
            CFG_EXP_VERSION: cur_version     = v;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] ver);
        settle();
        write_reg(CFG_SYNC_FIRST, s1);
        write_reg(CFG_SYNC_SECOND, s2);
        write_reg(CFG_EXP_VERSION, ver);
        // unmapped index must change nothing
        write_reg(CFG_IDX_SPARE, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch @%0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic check_feature_beat();
        feat_beat_t want;
        if (expected_feats.size() == 0) begin
            report("beat with none pending, feature_index", m_feature_index, 0);
            return;
        end
        want = expected_feats.pop_front();
        if (m_sequence_res !== want.seq)
            report("sequence_res", m_sequence_res, want.seq);
        if (m_tick_ms !== want.tick)
            report("tick_ms", m_tick_ms, want.tick);
        if (m_status_byte !== want.status)
            report("status_byte", m_status_byte, want.status);
        if (m_crc_value !== want.crc)
            report("crc_value", m_crc_value, want.crc);
        if (m_feature_index !== want.idx)
            report("feature_index", m_feature_index, want.idx);
        if (m_feature_value !== want.value)
            report("feature_value", m_feature_value, want.value);
        if (m_last_feature !== want.last)
            report("last_feature", m_last_feature, want.last);
    endtask

    // result side: check on handshake, then pick next cycle's ready
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                check_feature_beat();
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    task automatic test_sync_hunt();
        frame_t f;
        flush_to_hunt();
        f = build_frame(cur_version, FILL_EXTREMES);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_sync_second);
        send_byte(cur_sync_first);
        send_byte(8'h3C);                  // junk after first sync clears the hunt
        send_byte(cur_sync_first);
        send_byte(cur_sync_first);         // repeated first sync restarts
        send_frame(f, 1, FRAME_BYTES - 1);
    endtask

    task automatic test_bad_frames();
        flush_to_hunt();
        send_frame(build_frame(cur_version ^ 8'h80, FILL_RANDOM), 0, FRAME_BYTES - 1);
        flush_to_hunt();
        send_frame_behind_bad(9);
        flush_to_hunt();
        // first sync byte alone in the last slot
        send_frame_behind_bad(FRAME_BYTES - 1);
    endtask

    task automatic test_reg_change_mid_frame();
        frame_t f;
        flush_to_hunt();
        // version only matches once the register changes under the open frame
        f = build_frame(8'h7E, FILL_ONES);
        send_frame(f, 0, 11);
        set_regs(cur_sync_first, cur_sync_second, 8'h7E);
        send_frame(f, 12, FRAME_BYTES - 1);
        flush_to_hunt();
        // sync pair is checked again at frame end
        f = build_frame(cur_version, FILL_RANDOM);
        send_frame(f, 0, 11);
        set_regs(8'h3C, cur_sync_second, cur_version);
        send_frame(f, 12, FRAME_BYTES - 1);
        set_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, VERSION_RST);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input logic [7:0] s1, input logic [7:0] s2,
                                       input logic [7:0] ver);
        int unsigned byte_mark;
        int unsigned feat_mark;
        int          pick;
        int          n;
        frame_t      f;
        fill_t       fill;
        set_regs(s1, s2, ver);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        byte_mark    = bytes_sent;
        feat_mark    = feats_expected;
        while (bytes_sent - byte_mark < FRAME_BYTES ||
               feats_expected - feat_mark < FEATURE_COUNT) begin
            pick = $urandom_range(99);
            fill = ($urandom_range(3) == 0) ? FILL_EXTREMES : FILL_RANDOM;
            if (pick < 50) begin
                send_frame(build_frame(cur_version, fill), 0, FRAME_BYTES - 1);
            end else if (pick < 60) begin
                send_frame_behind_bad($urandom_range(1, FRAME_BYTES - 1));
            end else if (pick < 68) begin
                f = build_frame(cur_version, fill);
                f[CRC_POS + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
                send_frame(f, 0, FRAME_BYTES - 1);
            end else if (pick < 74) begin
                f = build_frame(cur_version ^ 8'($urandom_range(1, 255)), fill);
                send_frame(f, 0, FRAME_BYTES - 1);
            end else if (pick < 82) begin
                // frame cut short; the next one lands on top of it
                f = build_frame(cur_version, fill);
                send_frame(f, 0, $urandom_range(1, FRAME_BYTES - 2));
            end else if (pick < 92) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom));
            end else begin
                send_byte(cur_sync_first);
                send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sync_hunt();
        test_bad_frames();
        test_reg_change_mid_frame();
        test_random_traffic(48, 38, 8'h00, 8'hFF, 8'hFF);
        // both sync bytes the same value
        test_random_traffic(0, 0, 8'h5A, 8'h5A, 8'h80);
        settle();
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
